// File: sv/brbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbd_pkg
// Shared types, operation codes and defaults of the byte ring buffer deque.
// ----------------------------------------------------------------------------
package brbd_pkg;

	localparam int DEPTH_DEFAULT = 256;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] opcode_t;

	localparam opcode_t OP_PUSH_BACK  = 3'd0;
	localparam opcode_t OP_PUSH_FRONT = 3'd1;
	localparam opcode_t OP_POP        = 3'd2;
	localparam opcode_t OP_PEEK       = 3'd3;
	localparam opcode_t OP_FIND       = 3'd4;
	localparam opcode_t OP_CLEAR      = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic accept;       // transaction taken this cycle
		logic finish_read;  // read data of a pop or peek is ready
		logic scan;         // find scan in progress
	} brbd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic go_read;      // offered operation needs a memory read
		logic go_scan;      // offered operation needs a find scan
		logic scan_done;    // scan has a match or has passed the last byte
	} brbd_status_t;

endpackage

// File: sv/byte_ring_buffer_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_deque
// Byte ring buffer used as a deque with push back, push front, pop, peek,
// find and clear; one slot stays empty, so it holds at most DEPTH-1 bytes.
//
//   channel   handshake       payload
//   request   start / busy    opcode, data_in, offset
//   result    done (strobe)   data_out, ok, position, fill_count, free_count
//
// A transaction is taken on a clock edge with start high and busy low; its
// result shows on done for one cycle and cannot be held off.
// Push, clear, unknown codes and refused operations: result in the cycle after
// acceptance, busy stays low. Pop and peek: the read data is registered and then
// the result; busy high for one cycle while the memory read completes.
// Find reads one stored byte per cycle through the single memory read port
// and answers at the first match or, on a miss, once the last stored byte
// has been compared. Reset clears the indices at once; storage is not
// cleared and needs no pass.
// ----------------------------------------------------------------------------
module byte_ring_buffer_deque #(
	parameter int DEPTH = brbd_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  brbd_pkg::opcode_t opcode,
	input  brbd_pkg::byte_t   data_in,
	input  brbd_pkg::byte_t   offset,
	output logic              done,
	output brbd_pkg::byte_t   data_out,
	output logic              ok,
	output brbd_pkg::byte_t   position,
	output brbd_pkg::byte_t   fill_count,
	output brbd_pkg::byte_t   free_count
);
	import brbd_pkg::*;

	brbd_cmd_t    cmd;
	brbd_status_t st;

	brbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	brbd_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (opcode),
		.data_in    (data_in),
		.offset     (offset),
		.cmd        (cmd),
		.st         (st),
		.data_out   (data_out),
		.ok         (ok),
		.position   (position),
		.fill_count (fill_count),
		.free_count (free_count),
		.done       (done)
	);

endmodule

// File: sv/brbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbd_ctrl
// Controller: takes transactions and sequences reads and find scans.
// ----------------------------------------------------------------------------
module brbd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  brbd_pkg::brbd_status_t st,
	output brbd_pkg::brbd_cmd_t    cmd,
	output logic                  busy
);
	import brbd_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd.accept      = start && (state_q == S_IDLE);
		cmd.finish_read = (state_q == S_READ);
		cmd.scan        = (state_q == S_SCAN);
		busy            = (state_q != S_IDLE);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept && st.go_read) begin
					state_d = S_READ;
				end else if (cmd.accept && st.go_scan) begin
					state_d = S_SCAN;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (st.scan_done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/brbd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbd_dp
// Datapath: storage memory, head and tail indices, fill count, find scan
// pipeline and result registers.
// ----------------------------------------------------------------------------
module brbd_dp #(
	parameter int DEPTH = brbd_pkg::DEPTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  brbd_pkg::opcode_t      opcode,
	input  brbd_pkg::byte_t        data_in,
	input  brbd_pkg::byte_t        offset,
	input  brbd_pkg::brbd_cmd_t    cmd,
	output brbd_pkg::brbd_status_t st,
	output brbd_pkg::byte_t        data_out,
	output logic                   ok,
	output brbd_pkg::byte_t        position,
	output brbd_pkg::byte_t        fill_count,
	output brbd_pkg::byte_t        free_count,
	output logic                   done
);
	import brbd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int SW = ((AW > 8) ? AW : 8) + 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	byte_t mem [DEPTH];
	byte_t rdata_q;

	logic [AW-1:0] wr_q, rd_q, fill_q;
	logic [AW-1:0] wr_d, rd_d, fill_d;
	logic [AW-1:0] wr_next, rd_next, rd_prev;
	logic          full, empty;
	logic          imm_ok;

	logic [SW-1:0] peek_sum;
	logic [AW-1:0] peek_addr;
	logic          peek_ok;

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;

	logic [AW-1:0] scan_addr_q, scan_cnt_q, scan_addr_next;
	byte_t         key_q;
	logic          issue;
	logic          cmp_vld_s1;
	logic [AW-1:0] cmp_pos_s1;
	logic          hit;

	logic          imm_result;

	always_comb begin
		wr_next        = (wr_q == LAST) ? '0 : wr_q + 1'b1;
		rd_next        = (rd_q == LAST) ? '0 : rd_q + 1'b1;
		rd_prev        = (rd_q == '0) ? LAST : rd_q - 1'b1;
		scan_addr_next = (scan_addr_q == LAST) ? '0 : scan_addr_q + 1'b1;
		full           = (fill_q == LAST);
		empty          = (fill_q == '0);

		// head plus offset stays below twice the depth when the peek is in range
		peek_sum  = SW'(rd_q) + SW'(offset);
		peek_addr = (peek_sum >= SW'(DEPTH)) ? AW'(peek_sum - SW'(DEPTH)) : AW'(peek_sum);
		peek_ok   = SW'(offset) < SW'(fill_q);

		st.go_read = ((opcode == OP_POP) && !empty) || ((opcode == OP_PEEK) && peek_ok);
		st.go_scan = (opcode == OP_FIND) && !empty;

		hit          = (rdata_q == key_q);
		st.scan_done = cmp_vld_s1 && (hit || (cmp_pos_s1 == fill_q - 1'b1));
		issue        = cmd.scan && !st.scan_done && (scan_cnt_q < fill_q);

		imm_result = cmd.accept && !st.go_read && !st.go_scan;
	end

	// next index values for the operation on offer
	always_comb begin
		wr_d    = wr_q;
		rd_d    = rd_q;
		fill_d  = fill_q;
		imm_ok  = 1'b0;
		wr_en   = 1'b0;
		wr_addr = wr_q;
		case (opcode)
			OP_PUSH_BACK: begin
				if (!full) begin
					wr_d   = wr_next;
					fill_d = fill_q + 1'b1;
					imm_ok = 1'b1;
					wr_en  = cmd.accept;
				end
			end
			OP_PUSH_FRONT: begin
				if (!full) begin
					rd_d    = rd_prev;
					fill_d  = fill_q + 1'b1;
					imm_ok  = 1'b1;
					wr_en   = cmd.accept;
					wr_addr = rd_prev;
				end
			end
			OP_POP: begin
				if (!empty) begin
					rd_d   = rd_next;
					fill_d = fill_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				wr_d   = '0;
				rd_d   = '0;
				fill_d = '0;
				imm_ok = 1'b1;
			end
			default: begin
				imm_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		rd_en   = (cmd.accept && st.go_read) || issue;
		rd_addr = scan_addr_q;
		if (cmd.accept) begin
			rd_addr = (opcode == OP_POP) ? rd_q : peek_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= data_in;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			fill_q      <= '0;
			scan_addr_q <= '0;
			scan_cnt_q  <= '0;
			cmp_vld_s1  <= 1'b0;
			done        <= 1'b0;
		end else begin
			if (cmd.accept) begin
				wr_q   <= wr_d;
				rd_q   <= rd_d;
				fill_q <= fill_d;
			end
			if (cmd.accept && st.go_scan) begin
				scan_addr_q <= rd_q;
				scan_cnt_q  <= '0;
			end else if (issue) begin
				scan_addr_q <= scan_addr_next;
				scan_cnt_q  <= scan_cnt_q + 1'b1;
			end
			cmp_vld_s1 <= issue;
			done       <= imm_result || cmd.finish_read || (cmd.scan && st.scan_done);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && st.go_scan) begin
			key_q <= data_in;
		end
		cmp_pos_s1 <= scan_cnt_q;
		if (imm_result) begin
			data_out   <= '0;
			ok         <= imm_ok;
			position   <= '0;
			fill_count <= 8'(fill_d);
			free_count <= 8'(LAST - fill_d);
		end else if (cmd.finish_read) begin
			data_out   <= rdata_q;
			ok         <= 1'b1;
			position   <= '0;
			fill_count <= 8'(fill_q);
			free_count <= 8'(LAST - fill_q);
		end else if (cmd.scan && st.scan_done) begin
			data_out   <= '0;
			ok         <= hit;
			position   <= hit ? 8'(cmp_pos_s1) : 8'd0;
			fill_count <= 8'(fill_q);
			free_count <= 8'(LAST - fill_q);
		end
	end

endmodule

// File: sv/brbd_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbd_chk
// Port-level checks of the byte ring buffer deque, bound to the top level.
// ----------------------------------------------------------------------------
module brbd_chk #(
	parameter int DEPTH = brbd_pkg::DEPTH_DEFAULT
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input brbd_pkg::opcode_t opcode,
	input logic              done,
	input logic              ok,
	input brbd_pkg::byte_t   fill_count,
	input brbd_pkg::byte_t   free_count
);
	import brbd_pkg::*;

	// a result never overlaps a transaction still in progress
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// every result is owed to an accepted or running transaction
	a_done_owed: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy))
		else $error("result strobe with no transaction");

	// counts always add up to the capacity
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (8'(fill_count + free_count) == 8'(DEPTH - 1)))
		else $error("fill and free counts disagree");

	// operations without a memory read answer in the next cycle
	a_fast_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode != OP_POP && opcode != OP_PEEK && opcode != OP_FIND)
		|=> done)
		else $error("missing single-cycle result");

	// clear always succeeds and leaves the buffer empty
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_CLEAR) |=> (ok && fill_count == 8'd0))
		else $error("clear did not empty the buffer");

endmodule

bind byte_ring_buffer_deque brbd_chk #(
	.DEPTH (DEPTH)
) u_brbd_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.opcode     (opcode),
	.done       (done),
	.ok         (ok),
	.fill_count (fill_count),
	.free_count (free_count)
);

// File: tb/byte_ring_buffer_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_deque_tb
// Self-checking bench for the byte ring buffer deque. A short table of
// directed transactions covers the empty and wrapped buffer and every code.
// Random traffic follows: it first fills the buffer until pushes are
// refused, then mixes all codes. Every result is compared with a mirror of
// the ring in the bench or a typed row's result, under several sender idling patterns.
// ----------------------------------------------------------------------------
module byte_ring_buffer_deque_tb;
	import brbd_pkg::*;

	localparam int DEPTH        = DEPTH_DEFAULT;
	localparam int N_RANDOM     = 400;
	localparam int PHASE_LEN    = 80;
	localparam int LIMIT_CYCLES = 800000;
	localparam int N_DIRECTED   = 25;

	// codes with no operation behind them
	localparam opcode_t OP_UNUSED_6 = 3'd6;
	localparam opcode_t OP_UNUSED_7 = 3'd7;

	typedef struct packed {
		byte_t data;
		logic  ok;
		byte_t pos;
		byte_t fill;
		byte_t room;
	} deque_result_t;

	typedef struct {
		opcode_t       op;
		deque_result_t res;
	} awaited_t;

	typedef struct {
		opcode_t       op;
		byte_t         val;
		byte_t         off;
		bit            typed;
		deque_result_t want;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	opcode_t opcode = OP_PUSH_BACK;
	byte_t   data_in = '0;
	byte_t   offset = '0;
	logic    busy;
	logic    done;
	byte_t   data_out;
	logic    ok;
	byte_t   position;
	byte_t   fill_count;
	byte_t   free_count;

	// mirror of the ring
	byte_t ring_mem [DEPTH];
	int    head_slot = 0;
	int    tail_slot = 0;

	awaited_t      awaited_results [$];
	bit            row_typed = 1'b0;
	deque_result_t row_want = '0;
	int            idle_pct = 0;
	int            failures = 0;
	int            checked = 0;
	int            cycles = 0;
	int            op_seen [8];
	int            refused_pushes = 0;
	int            peak_fill = 0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{OP_POP,        8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 8'd0, 8'd255}},
		'{OP_PEEK,       8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 8'd0, 8'd255}},
		'{OP_FIND,       8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 8'd0, 8'd255}},
		'{OP_PUSH_BACK,  8'hFF, 8'h00, 1'b1, '{8'h00, 1'b1, 8'h00, 8'd1, 8'd254}},
		'{OP_PUSH_FRONT, 8'h00, 8'hFF, 1'b1, '{8'h00, 1'b1, 8'h00, 8'd2, 8'd253}},
		'{OP_PUSH_BACK,  8'hA5, 8'h00, 1'b0, '0},
		'{OP_PUSH_FRONT, 8'h5A, 8'h00, 1'b0, '0},
		'{OP_PEEK,       8'h00, 8'h00, 1'b0, '0},
		'{OP_PEEK,       8'h00, 8'h03, 1'b0, '0},
		'{OP_PEEK,       8'h00, 8'h04, 1'b0, '0},
		'{OP_PEEK,       8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b0, 8'h00, 8'd4, 8'd251}},
		'{OP_FIND,       8'hFF, 8'h00, 1'b0, '0},
		'{OP_FIND,       8'h5A, 8'h00, 1'b0, '0},
		'{OP_FIND,       8'h77, 8'h00, 1'b0, '0},
		'{OP_UNUSED_6,   8'h33, 8'h01, 1'b1, '{8'h00, 1'b0, 8'h00, 8'd4, 8'd251}},
		'{OP_UNUSED_7,   8'hCC, 8'h02, 1'b1, '{8'h00, 1'b0, 8'h00, 8'd4, 8'd251}},
		'{OP_POP,        8'h00, 8'h00, 1'b0, '0},
		'{OP_POP,        8'h00, 8'h00, 1'b0, '0},
		'{OP_CLEAR,      8'h00, 8'h00, 1'b1, '{8'h00, 1'b1, 8'h00, 8'd0, 8'd255}},
		'{OP_POP,        8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00, 8'd0, 8'd255}},
		'{OP_PUSH_FRONT, 8'h81, 8'h00, 1'b0, '0},
		'{OP_PEEK,       8'h00, 8'h00, 1'b0, '0},
		'{OP_POP,        8'h00, 8'h00, 1'b0, '0},
		'{OP_PUSH_BACK,  8'h7E, 8'h00, 1'b0, '0},
		'{OP_FIND,       8'h7E, 8'h00, 1'b0, '0}
	};

	byte_ring_buffer_deque #(
		.DEPTH(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.data_in   (data_in),
		.offset    (offset),
		.done      (done),
		.data_out  (data_out),
		.ok        (ok),
		.position  (position),
		.fill_count(fill_count),
		.free_count(free_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int ring_fill();
		return (tail_slot + DEPTH - head_slot) % DEPTH;
	endfunction

	// apply one operation to the mirror and return its result
	function automatic deque_result_t apply_deque_op(opcode_t op, byte_t val, byte_t off);
		deque_result_t r;
		int fill;
		int i;
		r = '0;
		fill = ring_fill();
		case (op)
			OP_PUSH_BACK: if (fill < DEPTH - 1) begin
				ring_mem[tail_slot] = val;
				tail_slot = (tail_slot + 1) % DEPTH;
				r.ok = 1'b1;
			end
			OP_PUSH_FRONT: if (fill < DEPTH - 1) begin
				head_slot = (head_slot + DEPTH - 1) % DEPTH;
				ring_mem[head_slot] = val;
				r.ok = 1'b1;
			end
			OP_POP: if (fill > 0) begin
				r.data = ring_mem[head_slot];
				head_slot = (head_slot + 1) % DEPTH;
				r.ok = 1'b1;
			end
			OP_PEEK: if (int'(off) < fill) begin
				r.data = ring_mem[(head_slot + int'(off)) % DEPTH];
				r.ok = 1'b1;
			end
			OP_FIND: begin
				for (i = 0; i < fill; i++) begin
					if (ring_mem[(head_slot + i) % DEPTH] == val) begin
						r.ok = 1'b1;
						r.pos = 8'(i);
						break;
					end
				end
			end
			OP_CLEAR: begin
				head_slot = 0;
				tail_slot = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		fill = ring_fill();
		r.fill = 8'(fill);
		r.room = 8'(DEPTH - 1 - fill);
		return r;
	endfunction

	task automatic flag_failure(input string msg);
		if (failures < 10)
			$display("[%0t] %s", $realtime, msg);
		failures++;
	endtask

	// check results first, then record the transaction taken at this edge
	always @(posedge clk) begin
		deque_result_t got;
		deque_result_t want;
		awaited_t      entry;
		if (arst_n) begin
			if (done) begin
				got = '{data_out, ok, position, fill_count, free_count};
				if (awaited_results.size() == 0) begin
					flag_failure($sformatf("unexpected result: data %02h ok %0b pos %0d fill %0d free %0d",
						got.data, got.ok, got.pos, got.fill, got.room));
				end else begin
					entry = awaited_results.pop_front();
					checked++;
					if (got !== entry.res)
						flag_failure($sformatf({"mismatch op %0d: expected data %02h ok %0b pos %0d ",
							"fill %0d free %0d, got data %02h ok %0b pos %0d fill %0d free %0d"},
							entry.op, entry.res.data, entry.res.ok, entry.res.pos, entry.res.fill,
							entry.res.room, got.data, got.ok, got.pos, got.fill, got.room));
				end
			end
			if (start && !busy) begin
				want = apply_deque_op(opcode, data_in, offset);
				if ((opcode == OP_PUSH_BACK || opcode == OP_PUSH_FRONT) && !want.ok)
					refused_pushes++;
				if (row_typed)
					want = row_want;
				awaited_results.push_back('{opcode, want});
				op_seen[opcode]++;
				if (ring_fill() > peak_fill)
					peak_fill = ring_fill();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				awaited_results.size());
			$display("byte_ring_buffer_deque test failed");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input opcode_t op, input byte_t val, input byte_t off,
			input bit typed, input deque_result_t want);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		data_in <= val;
		offset <= off;
		row_typed = typed;
		row_want = want;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// hold the sender until every result is back
	task automatic settle();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random transaction; while filling, push until full is refused a few times
	task automatic pick_random(input bit filling, output opcode_t op, output byte_t val,
			output byte_t off);
		int r;
		int fill;
		fill = ring_fill();
		r = $urandom_range(99);
		val = byte_t'($urandom_range(255));
		off = byte_t'($urandom_range(255));
		if (filling) begin
			if (r < 48)      op = OP_PUSH_BACK;
			else if (r < 92) op = OP_PUSH_FRONT;
			else if (r < 96) op = OP_PEEK;
			else if (r < 98) op = OP_FIND;
			else             op = OP_POP;
		end else begin
			if (r < 22)      op = OP_PUSH_BACK;
			else if (r < 40) op = OP_PUSH_FRONT;
			else if (r < 62) op = OP_POP;
			else if (r < 77) op = OP_PEEK;
			else if (r < 92) op = OP_FIND;
			else if (r < 96) op = OP_CLEAR;
			else if (r < 98) op = OP_UNUSED_6;
			else             op = OP_UNUSED_7;
		end
		// aim most peeks inside the stored bytes and most finds at a stored value
		if (op == OP_PEEK && fill > 0 && $urandom_range(3) != 0)
			off = byte_t'($urandom_range(fill - 1));
		if (op == OP_FIND && fill > 0 && $urandom_range(4) < 3)
			val = ring_mem[(head_slot + $urandom_range(fill - 1)) % DEPTH];
	endtask

	initial begin
		int      idle_plan [5];
		bit      filling;
		int      full_refusals;
		opcode_t op;
		byte_t   val;
		byte_t   off;
		idle_plan = '{0, 53, 15, 53, 0};
		filling = 1'b1;
		full_refusals = 0;
		for (int k = 0; k < DEPTH; k++)
			ring_mem[k] = '0;
		for (int k = 0; k < 8; k++)
			op_seen[k] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_item(directed_rows[k].op, directed_rows[k].val, directed_rows[k].off,
				directed_rows[k].typed, directed_rows[k].want);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % PHASE_LEN == 0) begin
				settle();
				idle_pct = idle_plan[(n / PHASE_LEN) % 5];
			end
			pick_random(filling, op, val, off);
			send_item(op, val, off, 1'b0, '0);
			if (filling && ring_fill() == DEPTH - 1 &&
					(op == OP_PUSH_BACK || op == OP_PUSH_FRONT)) begin
				full_refusals++;
				if (full_refusals > 6)
					filling = 1'b0;
			end
		end

		settle();
		// a find on a full ring is the slowest transaction
		repeat (DEPTH + 8) @(posedge clk);
		if (awaited_results.size() != 0)
			flag_failure($sformatf("%0d results never arrived", awaited_results.size()));

		$display("covered %0d directed and %0d random transactions: push back %0d, push front %0d,",
			N_DIRECTED, N_RANDOM, op_seen[OP_PUSH_BACK], op_seen[OP_PUSH_FRONT]);
		$display("pop %0d, peek %0d, find %0d, clear %0d, unused %0d; %0d refused pushes, peak fill %0d",
			op_seen[OP_POP], op_seen[OP_PEEK], op_seen[OP_FIND], op_seen[OP_CLEAR],
			op_seen[OP_UNUSED_6] + op_seen[OP_UNUSED_7], refused_pushes, peak_fill);
		if (failures == 0)
			$display("byte_ring_buffer_deque test passed");
		else
			$display("byte_ring_buffer_deque test failed");
		$finish;
	end

endmodule
